[sv/sbct_pkg.sv]
// ----------------------------------------------------------------------------
// sbct_pkg
// Shared types and constants for the bucketed checksum table.
// ----------------------------------------------------------------------------
package sbct_pkg;

	localparam int DEF_INDEX_BITS   = 10;
	localparam int DEF_BUCKET_DEPTH = 16;

	localparam int TAG_W = 16;
	localparam int OFF_W = 48;
	localparam int CNT_W = 15;
	localparam int CMD_W = 2;
	localparam int STS_W = 2;
	localparam int ENT_W = TAG_W + OFF_W;

	localparam logic [CNT_W-1:0] CNT_MAX = 15'h7fff;

	localparam logic [CMD_W-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MATCH   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEANSE = 2'd3;

	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_FULL = 2'd1;
	localparam logic [STS_W-1:0] STS_FAIL = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_RD,
		ST_CHK,
		ST_DECIDE,
		ST_SH_RD,
		ST_SH_WR,
		ST_INS_WR,
		ST_CL_FILL_RD,
		ST_CL_FILL,
		ST_CL_RD,
		ST_CL_CHK,
		ST_DONE
	} state_t;

endpackage

[sv/sorted_bucket_checksum_table.sv]
// ----------------------------------------------------------------------------
// sorted_bucket_checksum_table
// Bucketed checksum table with sorted 16-bit tags per bucket.
// ----------------------------------------------------------------------------
//  port group   dir   handshake            payload
//  in           in    in_valid/in_ready    command, checksum, offset_value
//  out          out   out_valid/out_ready  status, found_offset, entry_count
//  cfg          in    cfg_we               cfg_data (table_kind)
//
// After reset a clearing pass zeroes every bucket's fill count; no items
// are taken meanwhile. Lookup and match scan the bucket's sorted tags; insert
// also shifts the larger entries up a slot (scan plus shift, one entry port).
// With table_kind set, cleanse walks every bucket and packs nonzero offsets.
// One item at a time; a finished result waits in the output register.
// ----------------------------------------------------------------------------
module sorted_bucket_checksum_table #(
	parameter int INDEX_BITS   = sbct_pkg::DEF_INDEX_BITS,
	parameter int BUCKET_DEPTH = sbct_pkg::DEF_BUCKET_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [sbct_pkg::CMD_W-1:0] command,
	input  logic [31:0]                checksum,
	input  logic [sbct_pkg::OFF_W-1:0] offset_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sbct_pkg::STS_W-1:0] status,
	output logic [sbct_pkg::OFF_W-1:0] found_offset,
	output logic [sbct_pkg::CNT_W-1:0] entry_count
);

	import sbct_pkg::*;

	localparam int NB  = 1 << INDEX_BITS;
	localparam int FW  = $clog2(BUCKET_DEPTH + 1);
	localparam int EAW = $clog2(NB * BUCKET_DEPTH);

	logic                  fill_we, fill_re;
	logic [INDEX_BITS-1:0] fill_waddr, fill_raddr;
	logic [FW-1:0]         fill_wdata, fill_rdata;
	logic                  ent_we, ent_re;
	logic [EAW-1:0]        ent_waddr, ent_raddr;
	logic [ENT_W-1:0]      ent_wdata, ent_rdata;

	sbct_ram #(.DEPTH(NB), .WIDTH(FW), .ADDR_W(INDEX_BITS)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
		.re(fill_re), .raddr(fill_raddr), .rdata(fill_rdata)
	);

	sbct_ram #(.DEPTH(NB * BUCKET_DEPTH), .WIDTH(ENT_W), .ADDR_W(EAW)) u_ent (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
	);

	sbct_ctrl #(
		.INDEX_BITS(INDEX_BITS), .BUCKET_DEPTH(BUCKET_DEPTH), .FW(FW), .EAW(EAW)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.checksum(checksum), .offset_value(offset_value),
		.out_valid(out_valid), .out_ready(out_ready), .status(status),
		.found_offset(found_offset), .entry_count(entry_count),
		.fill_we(fill_we), .fill_waddr(fill_waddr), .fill_wdata(fill_wdata),
		.fill_re(fill_re), .fill_raddr(fill_raddr), .fill_rdata(fill_rdata),
		.ent_we(ent_we), .ent_waddr(ent_waddr), .ent_wdata(ent_wdata),
		.ent_re(ent_re), .ent_raddr(ent_raddr), .ent_rdata(ent_rdata)
	);

endmodule

[sv/sbct_ram.sv]
// ----------------------------------------------------------------------------
// sbct_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sbct_ram #(
	parameter int DEPTH  = 1024,
	parameter int WIDTH  = 8,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/sbct_ctrl.sv]
// ----------------------------------------------------------------------------
// sbct_ctrl
// Command sequencer: bucket scan, sorted insert shift, match fill, cleanse.
// ----------------------------------------------------------------------------
module sbct_ctrl #(
	parameter int INDEX_BITS   = sbct_pkg::DEF_INDEX_BITS,
	parameter int BUCKET_DEPTH = sbct_pkg::DEF_BUCKET_DEPTH,
	parameter int FW           = $clog2(BUCKET_DEPTH + 1),
	parameter int EAW          = $clog2((1 << INDEX_BITS) * BUCKET_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sbct_pkg::CMD_W-1:0]    command,
	input  logic [31:0]                   checksum,
	input  logic [sbct_pkg::OFF_W-1:0]    offset_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sbct_pkg::STS_W-1:0]    status,
	output logic [sbct_pkg::OFF_W-1:0]    found_offset,
	output logic [sbct_pkg::CNT_W-1:0]    entry_count,
	output logic                          fill_we,
	output logic [INDEX_BITS-1:0]         fill_waddr,
	output logic [FW-1:0]                 fill_wdata,
	output logic                          fill_re,
	output logic [INDEX_BITS-1:0]         fill_raddr,
	input  logic [FW-1:0]                 fill_rdata,
	output logic                          ent_we,
	output logic [EAW-1:0]                ent_waddr,
	output logic [sbct_pkg::ENT_W-1:0]    ent_wdata,
	output logic                          ent_re,
	output logic [EAW-1:0]                ent_raddr,
	input  logic [sbct_pkg::ENT_W-1:0]    ent_rdata
);

	import sbct_pkg::*;

	localparam int NB = 1 << INDEX_BITS;
	localparam logic [31:0] CAP = 32'(NB * BUCKET_DEPTH);
	localparam logic [FW-1:0] BD_F = FW'(BUCKET_DEPTH);
	localparam logic [INDEX_BITS-1:0] LAST_BKT = INDEX_BITS'(NB - 1);

	function automatic logic [EAW-1:0] ent_addr(input logic [INDEX_BITS-1:0] b,
		input logic [FW-1:0] s);
		logic [EAW:0] a;
		a = (EAW+1)'(b) * (EAW+1)'(BUCKET_DEPTH) + (EAW+1)'(s);
		return a[EAW-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
		input logic [FW-1:0] k);
		logic [CNT_W:0] t;
		t = {1'b0, c} + (CNT_W+1)'(k);
		return (t > {1'b0, CNT_MAX}) ? CNT_MAX : t[CNT_W-1:0];
	endfunction

	state_t state_q, state_d;

	logic                  kind_q, fin_q;
	logic [CNT_W-1:0]      cnt_q, total_q;
	logic [INDEX_BITS-1:0] clr_q, bkt_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [TAG_W-1:0]      tag_q;
	logic [OFF_W-1:0]      off_q, hitoff_q;
	logic [FW-1:0]         n_q, i_q, j_q, k_q;
	logic                  found_q;
	logic [STS_W-1:0]      res_sts_q;
	logic [OFF_W-1:0]      res_off_q;
	logic                  out_valid_q;
	logic [STS_W-1:0]      status_q;
	logic [OFF_W-1:0]      found_offset_q;
	logic [CNT_W-1:0]      entry_count_q;

	logic [TAG_W-1:0] rd_tag;
	logic [OFF_W-1:0] rd_off;
	logic             out_free;

	assign rd_tag   = ent_rdata[ENT_W-1:OFF_W];
	assign rd_off   = ent_rdata[OFF_W-1:0];
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		fill_we    = 1'b0;
		fill_waddr = bkt_q;
		fill_wdata = n_q + FW'(1);
		fill_re    = 1'b0;
		fill_raddr = bkt_q;
		ent_we     = 1'b0;
		ent_waddr  = ent_addr(bkt_q, i_q);
		ent_wdata  = {tag_q, off_q};
		ent_re     = 1'b0;
		ent_raddr  = ent_addr(bkt_q, i_q);
		case (state_q)
			ST_CLEAR: begin
				fill_we    = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
				if (clr_q == LAST_BKT) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (command == CMD_CLEANSE) begin
						state_d = kind_q ? ST_CL_FILL_RD : ST_DONE;
					end else if (command == CMD_MATCH && (!kind_q || fin_q)) begin
						state_d = ST_DONE;
					end else begin
						fill_re    = 1'b1;
						fill_raddr = checksum[INDEX_BITS-1:0];
						state_d    = ST_FILL;
					end
				end
			end
			ST_FILL: begin
				if (cmd_q == CMD_INSERT && fill_rdata >= BD_F) state_d = ST_DONE;
				else state_d = ST_RD;
			end
			ST_RD: begin
				if (i_q == n_q) begin
					state_d = ST_DECIDE;
				end else begin
					ent_re  = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = (rd_tag < tag_q) ? ST_RD : ST_DECIDE;
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_INSERT && !found_q) begin
					state_d = ST_SH_RD;
				end else begin
					if (cmd_q == CMD_MATCH && found_q && hitoff_q == '0) ent_we = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_SH_RD: begin
				if (j_q == i_q) begin
					state_d = ST_INS_WR;
				end else begin
					ent_re    = 1'b1;
					ent_raddr = ent_addr(bkt_q, j_q - FW'(1));
					state_d   = ST_SH_WR;
				end
			end
			ST_SH_WR: begin
				ent_we    = 1'b1;
				ent_waddr = ent_addr(bkt_q, j_q);
				ent_wdata = ent_rdata;
				state_d   = ST_SH_RD;
			end
			ST_INS_WR: begin
				ent_we    = 1'b1;
				ent_wdata = {tag_q, kind_q ? OFF_W'(0) : off_q};
				fill_we   = 1'b1;
				state_d   = ST_DONE;
			end
			ST_CL_FILL_RD: begin
				fill_re = 1'b1;
				state_d = ST_CL_FILL;
			end
			ST_CL_FILL: begin
				state_d = ST_CL_RD;
			end
			ST_CL_RD: begin
				if (i_q == n_q) begin
					fill_we    = 1'b1;
					fill_wdata = k_q;
					state_d    = (bkt_q == LAST_BKT) ? ST_DONE : ST_CL_FILL_RD;
				end else begin
					ent_re  = 1'b1;
					state_d = ST_CL_CHK;
				end
			end
			ST_CL_CHK: begin
				// keep entries whose offset is nonzero, packed down to slot k
				if (rd_off != '0) begin
					ent_we    = 1'b1;
					ent_waddr = ent_addr(bkt_q, k_q);
					ent_wdata = ent_rdata;
				end
				state_d = ST_CL_RD;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q      <= 1'b0;
			fin_q       <= 1'b0;
			cnt_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) kind_q <= cfg_data;
			if (state_q == ST_CLEAR) clr_q <= clr_q + INDEX_BITS'(1);
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_DECIDE: begin
					if (cmd_q == CMD_MATCH && found_q && hitoff_q == '0)
						cnt_q <= sat_add(cnt_q, FW'(1));
				end
				ST_INS_WR: cnt_q <= sat_add(cnt_q, FW'(1));
				ST_CL_RD: begin
					if (i_q == n_q && bkt_q == LAST_BKT) begin
						cnt_q <= sat_add(total_q, k_q);
						fin_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q     <= command;
				bkt_q     <= command == CMD_CLEANSE ? '0 : checksum[INDEX_BITS-1:0];
				tag_q     <= checksum[31:16];
				off_q     <= offset_value;
				total_q   <= '0;
				found_q   <= 1'b0;
				res_sts_q <= (command == CMD_CLEANSE && kind_q) ? STS_OK : STS_FAIL;
				res_off_q <= '0;
			end
			ST_FILL: begin
				n_q <= fill_rdata;
				i_q <= '0;
			end
			ST_CHK: begin
				if (rd_tag < tag_q) begin
					i_q <= i_q + FW'(1);
				end else begin
					found_q  <= rd_tag == tag_q;
					hitoff_q <= rd_off;
				end
			end
			ST_DECIDE: begin
				j_q <= n_q;
				if (cmd_q == CMD_LOOKUP && found_q) begin
					res_sts_q <= STS_OK;
					res_off_q <= hitoff_q;
				end
				if (cmd_q == CMD_MATCH && found_q && hitoff_q == '0) res_sts_q <= STS_OK;
			end
			ST_SH_WR: j_q <= j_q - FW'(1);
			ST_INS_WR: begin
				res_sts_q <= (n_q != '0 && {17'd0, cnt_q} + 32'd1 == CAP) ? STS_FULL : STS_OK;
			end
			ST_CL_FILL: begin
				n_q <= fill_rdata;
				i_q <= '0;
				k_q <= '0;
			end
			ST_CL_RD: begin
				if (i_q == n_q) begin
					total_q <= sat_add(total_q, k_q);
					bkt_q   <= bkt_q + INDEX_BITS'(1);
				end
			end
			ST_CL_CHK: begin
				i_q <= i_q + FW'(1);
				if (rd_off != '0) k_q <= k_q + FW'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					status_q       <= res_sts_q;
					found_offset_q <= res_off_q;
					entry_count_q  <= cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_offset = found_offset_q;
	assign entry_count  = entry_count_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD || state_q == ST_CL_RD) |-> (n_q <= BD_F && i_q <= n_q))
		else $error("scan index past bucket fill");

	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CL_RD || state_q == ST_CL_CHK) |-> (k_q <= i_q))
		else $error("compaction write ahead of read");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SH_RD) |-> (j_q >= i_q && j_q < BD_F))
		else $error("insert shift out of range");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ent_we && ent_re))
		else $error("entry read and write in same cycle");

endmodule
